FILE: rtl/core/rths_pkg.sv
// Shared types and constants for the RGB to HSV conversion pipeline.
package rths_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned HUE_W = 11;
  localparam int unsigned QUO_W = CHAN_W + 1;
  localparam int unsigned SEG_W = 3;
  localparam int unsigned NUM_CELLS = QUO_W;

  localparam logic [SEG_W-1:0] SEG_RED_YELLOW   = 3'd0;
  localparam logic [SEG_W-1:0] SEG_YELLOW_GREEN = 3'd1;
  localparam logic [SEG_W-1:0] SEG_GREEN_CYAN   = 3'd2;
  localparam logic [SEG_W-1:0] SEG_CYAN_BLUE    = 3'd3;
  localparam logic [SEG_W-1:0] SEG_BLUE_MAGENTA = 3'd4;
  localparam logic [SEG_W-1:0] SEG_MAGENTA_RED  = 3'd5;

  localparam logic [HUE_W-1:0] HUE_MAX = 11'd1535;
  localparam logic [HUE_W-1:0] OFFSET_TOP = 11'd255;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [QUO_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
    logic [SEG_W-1:0]  seg;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bright;
  } div_t;

endpackage

FILE: rtl/core/rths_front.sv
// Front stage: finds max, min, mid channel and hue segment, and registers the segment with mid-min, max-min and max.
module rths_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rths_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rths_pkg::div_t  out_data
);

  logic [rths_pkg::CHAN_W-1:0] r, g, b, v, lo, mid;
  logic [rths_pkg::SEG_W-1:0]  seg;
  logic                        valid;
  rths_pkg::div_t              data, data_next;

  assign r = in_data.red;
  assign g = in_data.green;
  assign b = in_data.blue;

  always_comb begin
    v = (r > g) ? r : g;
    v = (v > b) ? v : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    priority if (v == r) begin
      mid = (g > b) ? g : b;
    end else if (v == g) begin
      mid = (r > b) ? r : b;
    end else begin
      mid = (r > g) ? r : g;
    end
    priority if (v == r && lo == b && v != g) begin
      seg = rths_pkg::SEG_RED_YELLOW;
    end else if (v == g && lo == b && lo != r) begin
      seg = rths_pkg::SEG_YELLOW_GREEN;
    end else if (v == g && lo == r && v != b) begin
      seg = rths_pkg::SEG_GREEN_CYAN;
    end else if (v == b && lo == r && lo != g) begin
      seg = rths_pkg::SEG_CYAN_BLUE;
    end else if (v == b && lo == g && v != r) begin
      seg = rths_pkg::SEG_BLUE_MAGENTA;
    end else begin
      seg = rths_pkg::SEG_MAGENTA_RED;
    end
    data_next.rem = {1'b0, mid - lo};
    data_next.quo = '0;
    data_next.seg = seg;
    data_next.sat = v - lo;
    data_next.bright = v;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data = data;

endmodule

FILE: rtl/core/rths_cell.sv
// Divider cell: one restoring step that yields one quotient bit per stage.
module rths_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rths_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rths_pkg::div_t out_data
);

  logic                        valid;
  logic                        fits;
  logic [rths_pkg::QUO_W-1:0]  divisor;
  logic [rths_pkg::QUO_W-1:0]  trial;
  rths_pkg::div_t              data, data_next;

  always_comb begin
    divisor = {1'b0, in_data.sat};
    fits = in_data.rem >= divisor;
    trial = fits ? (in_data.rem - divisor) : in_data.rem;
    data_next = in_data;
    data_next.rem = {trial[rths_pkg::QUO_W-2:0], 1'b0};
    data_next.quo = {in_data.quo[rths_pkg::QUO_W-2:0], fits};
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data = data;

endmodule

FILE: rtl/core/rgb_to_hsv_six_segment_core.sv
// Top level of the pipelined RGB to HSV converter.
//
// The pixel channel carries one RGB word per accepted handshake; the hsv
// channel returns one word holding hue, saturation and brightness for each.
// A word is taken at a clock edge where valid is high and stall is low.
// Throughput is one pixel per clock cycle when the hsv side does not stall.
// From an accepted pixel to its result being valid, a pixel passes through
// one front stage that finds the extremes and the hue segment, a row of nine
// divider cells that each resolve one bit of the hue offset, and one output
// register that forms the final hue.
// Every stage holds a valid flag and advances whenever the stage after it
// is empty or moving, so bubbles close up and new pixels are taken while a
// finished result still waits at the output.
// When the receiver stalls, the output word holds and the pipeline fills up;
// pixel_stall rises only once every stage is occupied.
// Reset clears all valid flags, so no word is presented after reset.
module rgb_to_hsv_six_segment_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  rths_pkg::pixel_t pixel,
  output logic             hsv_valid,
  input  logic             hsv_stall,
  output rths_pkg::hsv_t   hsv
);

  logic                   stage_valid [rths_pkg::NUM_CELLS+1];
  logic                   stage_ready [rths_pkg::NUM_CELLS+1];
  rths_pkg::div_t         stage_data  [rths_pkg::NUM_CELLS+1];
  logic                   front_ready;
  logic                   out_ready;
  logic                   valid;
  rths_pkg::hsv_t         data, data_next;
  rths_pkg::div_t         last;

  rths_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_ready  (front_ready),
    .in_data   (pixel),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_data  (stage_data[0])
  );

  assign pixel_stall = !front_ready;

  for (genvar i = 0; i < rths_pkg::NUM_CELLS; i++) begin : g_cell
    rths_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  assign last = stage_data[rths_pkg::NUM_CELLS];
  assign out_ready = !valid || !hsv_stall;
  assign stage_ready[rths_pkg::NUM_CELLS] = out_ready;

  always_comb begin
    data_next.saturation = last.sat;
    data_next.brightness = last.bright;
    if (last.sat == '0) begin
      data_next.hue = '0;
    end else if (last.seg[0]) begin
      data_next.hue = {last.seg, 8'b0} + rths_pkg::OFFSET_TOP - {2'b0, last.quo};
    end else begin
      data_next.hue = {last.seg, 8'b0} + {2'b0, last.quo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_ready) begin
      valid <= stage_valid[rths_pkg::NUM_CELLS];
    end
    if (stage_valid[rths_pkg::NUM_CELLS] && out_ready) begin
      data <= data_next;
    end
  end

  assign hsv_valid = valid;
  assign hsv = data;

  a_grey_hue_zero: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.saturation == '0 |-> hsv.hue == '0)
    else $error("grey pixel produced a nonzero hue");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.hue <= rths_pkg::HUE_MAX)
    else $error("hue out of range");

  a_sat_below_value: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.saturation <= hsv.brightness)
    else $error("saturation exceeds brightness");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage_valid[0] |-> !pixel_stall)
    else $error("input stalled while front stage is empty");

endmodule

FILE: verif/rgb_to_hsv_six_segment_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined RGB to HSV converter core.
module rgb_to_hsv_six_segment_core_tb;

  localparam int unsigned SEG_SPAN = 256;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned MAX_SHOWN = 10;

  logic             clk;
  logic             rst;
  logic             pixel_valid;
  logic             pixel_stall;
  rths_pkg::pixel_t pixel;
  logic             hsv_valid;
  logic             hsv_stall;
  rths_pkg::hsv_t   hsv;

  rths_pkg::hsv_t hsv_expected[$];
  int unsigned    mismatches;
  bit             tx_idle_on;
  bit             rx_idle_on;
  int unsigned    rx_hold_cycles;

  rgb_to_hsv_six_segment_core dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hsv         (hsv)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rths_pkg::hsv_t convert_pixel(rths_pkg::pixel_t p);
    int unsigned r, g, b, v, lo, s, mid, q, hue_sum;
    logic [rths_pkg::SEG_W-1:0] seg;
    rths_pkg::hsv_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    v = (r > g) ? r : g;
    if (b > v) v = b;
    lo = (r < g) ? r : g;
    if (b < lo) lo = b;
    s = v - lo;
    res.hue = '0;
    if (s != 0) begin
      if (v == r) mid = (g > b) ? g : b;
      else if (v == g) mid = (r > b) ? r : b;
      else mid = (r > g) ? r : g;
      if (v == r && lo == b && v != g) seg = rths_pkg::SEG_RED_YELLOW;
      else if (v == g && lo == b && lo != r) seg = rths_pkg::SEG_YELLOW_GREEN;
      else if (v == g && lo == r && v != b) seg = rths_pkg::SEG_GREEN_CYAN;
      else if (v == b && lo == r && lo != g) seg = rths_pkg::SEG_CYAN_BLUE;
      else if (v == b && lo == g && v != r) seg = rths_pkg::SEG_BLUE_MAGENTA;
      else seg = rths_pkg::SEG_MAGENTA_RED;
      q = ((mid - lo) * SEG_SPAN) / s;
      if (seg[0] == 1'b0) hue_sum = seg * SEG_SPAN + q;
      else hue_sum = seg * SEG_SPAN + rths_pkg::OFFSET_TOP - q;
      res.hue = hue_sum[rths_pkg::HUE_W-1:0];
    end
    res.saturation = s[rths_pkg::CHAN_W-1:0];
    res.brightness = v[rths_pkg::CHAN_W-1:0];
    return res;
  endfunction

  function automatic rths_pkg::pixel_t rgb(int unsigned r, int unsigned g, int unsigned b);
    rths_pkg::pixel_t p;
    p.red = r[rths_pkg::CHAN_W-1:0];
    p.green = g[rths_pkg::CHAN_W-1:0];
    p.blue = b[rths_pkg::CHAN_W-1:0];
    return p;
  endfunction

  function automatic rths_pkg::pixel_t random_pixel();
    int unsigned a, c;
    a = $urandom_range(0, 255);
    c = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: begin
        return rgb(a, a, a);
      end
      1, 2, 3: begin
        case ($urandom_range(0, 2))
          0: return rgb(a, a, c);
          1: return rgb(a, c, a);
          default: return rgb(c, a, a);
        endcase
      end
      default: begin
        return rgb(a, c, $urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic send_pixel(rths_pkg::pixel_t p);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (pixel_stall);
    hsv_expected.push_back(convert_pixel(p));
  endtask

  task automatic wait_for_results();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (hsv_expected.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rths_pkg::hsv_t want;
    if (!rst && hsv_valid && !hsv_stall) begin
      if (hsv_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected hsv word: hue=%0d sat=%0d val=%0d",
                   hsv.hue, hsv.saturation, hsv.brightness);
      end else begin
        want = hsv_expected.pop_front();
        if (hsv.hue !== want.hue || hsv.saturation !== want.saturation ||
            hsv.brightness !== want.brightness) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display(
              "hsv mismatch: expected hue=%0d sat=%0d val=%0d, got hue=%0d sat=%0d val=%0d",
              want.hue, want.saturation, want.brightness,
              hsv.hue, hsv.saturation, hsv.brightness);
        end
      end
    end
  end

  initial begin
    hsv_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        hsv_stall <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        hsv_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        hsv_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        hsv_stall <= 1'b0;
      end
    end
  end

  task automatic test_corner_pixels();
    send_pixel(rgb(0, 0, 0));
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(128, 128, 128));
    send_pixel(rgb(255, 0, 0));
    send_pixel(rgb(0, 255, 0));
    send_pixel(rgb(0, 0, 255));
    send_pixel(rgb(255, 255, 0));
    send_pixel(rgb(0, 255, 255));
    send_pixel(rgb(255, 0, 255));
    send_pixel(rgb(255, 128, 0));
    send_pixel(rgb(128, 255, 0));
    send_pixel(rgb(0, 255, 128));
    send_pixel(rgb(0, 128, 255));
    send_pixel(rgb(128, 0, 255));
    send_pixel(rgb(255, 0, 128));
    send_pixel(rgb(200, 100, 100));
    send_pixel(rgb(100, 200, 200));
    send_pixel(rgb(100, 100, 200));
    send_pixel(rgb(1, 0, 0));
    send_pixel(rgb(255, 254, 0));
    send_pixel(rgb(255, 0, 1));
    send_pixel(rgb(170, 85, 1));
  endtask

  task automatic test_random_with_idling(int unsigned count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(random_pixel());
      if (i == count / 2) wait_for_results();
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_cycles = 80;
    for (int unsigned i = 0; i < 50; i++) send_pixel(random_pixel());
    wait_for_results();
  endtask

  task automatic test_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int unsigned i = 0; i < 60; i++) send_pixel(random_pixel());
  endtask

  initial begin
    rst <= 1'b1;
    pixel_valid <= 1'b0;
    pixel <= '0;
    mismatches = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_pixels();
    test_random_with_idling(280);
    test_output_backpressure();
    test_full_rate();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (hsv_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && hsv_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rths_pkg.sv
rtl/core/rths_front.sv
rtl/core/rths_cell.sv
rtl/core/rgb_to_hsv_six_segment_core.sv
verif/rgb_to_hsv_six_segment_core_tb.sv
